// ===== hw/rtl/perf_counter_stats_table_macros.svh =====
// Assertion macros for the performance statistics table.
`ifndef PERF_COUNTER_STATS_TABLE_MACROS_SVH
`define PERF_COUNTER_STATS_TABLE_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define PCST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcst: same-cycle check failed");

// Checks that a condition implies another in the following cycle.
`define PCST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcst: next-cycle check failed");

`endif

// ===== hw/rtl/pcst_pkg.sv =====
// Package with types, codes and constants of the performance statistics table.
`timescale 1ns / 1ps

package pcst_pkg;

    localparam int PCST_CPU_COUNT    = 2;
    localparam int PCST_SCENE_COUNT  = 8;
    localparam int PCST_METRIC_COUNT = 8;
    localparam int PCST_OTHER_SCENE  = 0;

    localparam int CPU_W    = 2;
    localparam int SCENE_W  = 4;
    localparam int METRIC_W = 4;
    localparam int SPR_W    = 3;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int TICK_W   = 16;
    localparam int ADDR_W   = 29;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_SPRITE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCENE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_METRIC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_FAST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_SLOW   = 2'd3;

    localparam logic [SCENE_W-1:0] CURRENT_SCENE_RESET = 4'd0;
    localparam logic [SPR_W-1:0]   SPRITE_METRIC_RESET = 3'd0;
    localparam logic [SPR_W-1:0]   SPRITE_FAST_RESET   = 3'd1;
    localparam logic [SPR_W-1:0]   SPRITE_SLOW_RESET   = 3'd2;

    localparam logic [ADDR_W-1:0] WINDOW_LOW  = 29'h0600_0000;
    localparam logic [ADDR_W-1:0] WINDOW_HIGH = 29'h0604_0000;

    typedef struct packed {
        logic [1:0]          op;
        logic [CPU_W-1:0]    cpu;
        logic [METRIC_W-1:0] metric;
        logic [31:0]         elapsed;
        logic [31:0]         source_address;
        logic [SCENE_W-1:0]  read_scene;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] tick_total;
        logic [31:0] call_total;
        logic [15:0] peak_ticks;
    } rsp_t;

    typedef struct packed {
        logic [31:0]       sum;
        logic [31:0]       count;
        logic [TICK_W-1:0] peak;
    } entry_t;

endpackage

// ===== hw/rtl/perf_counter_stats_table.sv =====
// Top level of the performance statistics table: one counter memory with read-modify-write.
// A record or read item gives its result after one read of its entry, a sprite record after
// two updates through the one memory port, and a clear after it has swept every entry, of
// which there are DEPTH = CPU_COUNT * SCENE_COUNT * METRIC_COUNT. Input is ready again as
// the result appears, so a new item is taken only once the last one's result has appeared.
// After reset the memory is swept and no item is taken; cfg writes land at once.
`timescale 1ns / 1ps

module perf_counter_stats_table
    import pcst_pkg::*;
#(
    parameter int CPU_COUNT    = PCST_CPU_COUNT,
    parameter int SCENE_COUNT  = PCST_SCENE_COUNT,
    parameter int METRIC_COUNT = PCST_METRIC_COUNT,
    parameter int OTHER_SCENE  = PCST_OTHER_SCENE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp
);

    `include "perf_counter_stats_table_macros.svh"

    localparam int DEPTH = CPU_COUNT * SCENE_COUNT * METRIC_COUNT;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int FALLBACK_SCENE = (OTHER_SCENE < SCENE_COUNT) ? OTHER_SCENE : SCENE_COUNT - 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RMW   = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    function automatic logic [IDX_W-1:0] entry_index(input logic [CPU_W-1:0] c,
                                                     input logic [SCENE_W-1:0] s,
                                                     input logic [METRIC_W-1:0] m);
        logic [31:0] full;
        full = (32'(c) * 32'(SCENE_COUNT) + 32'(s)) * 32'(METRIC_COUNT) + 32'(m);
        return full[IDX_W-1:0];
    endfunction

    entry_t stat_mem [DEPTH];
    entry_t mem_rdata_reg;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    logic [SCENE_W-1:0] current_scene_reg;
    logic [SPR_W-1:0]   sprite_metric_reg;
    logic [SPR_W-1:0]   sprite_fast_reg;
    logic [SPR_W-1:0]   sprite_slow_reg;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic              clr_report_reg, clr_report_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              fwd_valid_reg, fwd_valid_next;

    logic [1:0]        op_reg, op_next;
    logic              phase_reg, phase_next;
    logic              ok_reg, ok_next;
    logic              ok2_reg, ok2_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  addr2_reg, addr2_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              status_acc_reg, status_acc_next;
    rsp_t              rsp_reg, rsp_next;
    rsp_t              pend_reg, pend_next;
    entry_t            fwd_data_reg, fwd_data_next;
    logic [IDX_W-1:0]  fwd_addr_reg, fwd_addr_next;

    logic               accept;
    logic               out_free;
    logic               finish;
    rsp_t               fin_rsp;
    entry_t             src;
    entry_t             upd;
    logic               cpu_ok;
    logic [SCENE_W-1:0] active_scene;
    logic [METRIC_W-1:0] metric_a;
    logic [METRIC_W-1:0] metric_b;
    logic [SCENE_W-1:0] scene_a;
    logic               ok_a;
    logic               ok_b;
    logic [ADDR_W-1:0]  src_addr;
    logic               window_hit;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign active_scene = (32'(current_scene_reg) < 32'(SCENE_COUNT)) ?
                          current_scene_reg : SCENE_W'(FALLBACK_SCENE);
    assign src_addr     = req.source_address[ADDR_W-1:0];
    assign window_hit   = (src_addr >= WINDOW_LOW) && (src_addr < WINDOW_HIGH);
    assign cpu_ok       = 32'(req.cpu) < 32'(CPU_COUNT);
    assign metric_b     = window_hit ? METRIC_W'(sprite_fast_reg) : METRIC_W'(sprite_slow_reg);
    assign ok_b         = cpu_ok && (32'(metric_b) < 32'(METRIC_COUNT));

    always_comb
    begin
        unique case (req.op)
            OP_RECORD:
            begin
                metric_a = req.metric;
                scene_a  = active_scene;
                ok_a     = cpu_ok && (32'(req.metric) < 32'(METRIC_COUNT));
            end
            OP_SPRITE:
            begin
                metric_a = METRIC_W'(sprite_metric_reg);
                scene_a  = active_scene;
                ok_a     = cpu_ok && (32'(sprite_metric_reg) < 32'(METRIC_COUNT));
            end
            OP_READ:
            begin
                metric_a = req.metric;
                scene_a  = req.read_scene;
                ok_a     = cpu_ok && (32'(req.metric) < 32'(METRIC_COUNT))
                           && (32'(req.read_scene) < 32'(SCENE_COUNT));
            end
            default:
            begin
                metric_a = req.metric;
                scene_a  = active_scene;
                ok_a     = 1'b0;
            end
        endcase
    end

    // The entry written in the previous cycle is forwarded when it is read again at once.
    assign src = (fwd_valid_reg && (fwd_addr_reg == addr_reg)) ? fwd_data_reg : mem_rdata_reg;

    always_comb
    begin
        upd.sum   = src.sum + 32'(ticks_reg);
        upd.count = src.count + 32'd1;
        upd.peak  = (ticks_reg > src.peak) ? ticks_reg : src.peak;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        clr_report_next = clr_report_reg;
        rsp_valid_next  = rsp_valid_reg;
        op_next         = op_reg;
        phase_next      = phase_reg;
        ok_next         = ok_reg;
        ok2_next        = ok2_reg;
        addr_next       = addr_reg;
        addr2_next      = addr2_reg;
        ticks_next      = ticks_reg;
        status_acc_next = status_acc_reg;
        rsp_next        = rsp_reg;
        pend_next       = pend_reg;
        mem_rd_en       = 1'b0;
        mem_raddr       = addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = upd;
        finish          = 1'b0;
        fin_rsp         = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    if (clr_report_reg)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.op;
                    phase_next      = 1'b0;
                    status_acc_next = 1'b0;
                    ok_next         = ok_a;
                    ok2_next        = ok_b;
                    addr_next       = entry_index(req.cpu, scene_a, metric_a);
                    addr2_next      = entry_index(req.cpu, active_scene, metric_b);
                    ticks_next      = req.elapsed[TICK_W-1:0];
                    if (req.op == OP_CLEAR)
                    begin
                        state_next      = S_CLEAR;
                        clr_idx_next    = '0;
                        clr_report_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_RMW;
                        mem_rd_en  = 1'b1;
                        mem_raddr  = entry_index(req.cpu, scene_a, metric_a);
                    end
                end
            end
            S_RMW:
            begin
                if (((op_reg == OP_RECORD) || (op_reg == OP_SPRITE)) && ok_reg)
                begin
                    mem_we = 1'b1;
                end
                if ((op_reg == OP_SPRITE) && !phase_reg)
                begin
                    phase_next      = 1'b1;
                    status_acc_next = !ok_reg;
                    ok_next         = ok2_reg;
                    addr_next       = addr2_reg;
                    mem_rd_en       = 1'b1;
                    mem_raddr       = addr2_reg;
                end
                else
                begin
                    finish         = 1'b1;
                    fin_rsp.status = status_acc_reg | !ok_reg;
                    if ((op_reg == OP_READ) && ok_reg)
                    begin
                        fin_rsp.tick_total = src.sum;
                        fin_rsp.call_total = src.count;
                        fin_rsp.peak_ticks = src.peak;
                    end
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                rsp_next       = fin_rsp;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = fin_rsp;
                state_next = S_WAIT;
            end
        end
    end

    assign fwd_valid_next = (state_reg == S_RMW) && mem_we;
    assign fwd_data_next  = mem_wdata;
    assign fwd_addr_next  = addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stat_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd_en)
        begin
            mem_rdata_reg <= stat_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_scene_reg <= CURRENT_SCENE_RESET;
            sprite_metric_reg <= SPRITE_METRIC_RESET;
            sprite_fast_reg   <= SPRITE_FAST_RESET;
            sprite_slow_reg   <= SPRITE_SLOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CURRENT_SCENE: current_scene_reg <= cfg_data[SCENE_W-1:0];
                REG_SPRITE_METRIC: sprite_metric_reg <= cfg_data[SPR_W-1:0];
                REG_SPRITE_FAST:   sprite_fast_reg   <= cfg_data[SPR_W-1:0];
                REG_SPRITE_SLOW:   sprite_slow_reg   <= cfg_data[SPR_W-1:0];
                default:           sprite_slow_reg   <= sprite_slow_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            clr_report_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            clr_report_reg <= clr_report_next;
            rsp_valid_reg  <= rsp_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        phase_reg      <= phase_next;
        ok_reg         <= ok_next;
        ok2_reg        <= ok2_next;
        addr_reg       <= addr_next;
        addr2_reg      <= addr2_next;
        ticks_reg      <= ticks_next;
        status_acc_reg <= status_acc_next;
        rsp_reg        <= rsp_next;
        pend_reg       <= pend_next;
        fwd_data_reg   <= fwd_data_next;
        fwd_addr_reg   <= fwd_addr_next;
    end

    `PCST_ASSERT_NEXT(a_accept_to_rmw, accept && (req.op != OP_CLEAR), state_reg == S_RMW)
    `PCST_ASSERT_SAME(a_write_only_record,
        (state_reg == S_RMW) && mem_we, (op_reg == OP_RECORD) || (op_reg == OP_SPRITE))
    `PCST_ASSERT_SAME(a_wait_holds_output, state_reg == S_WAIT, rsp_valid_reg)
    `PCST_ASSERT_SAME(a_forward_only_sprite, fwd_valid_reg && (state_reg == S_RMW), phase_reg)

endmodule

// ===== tb/pcst_stats_checker.sv =====
// Checker that follows the statistics table from its channels and compares every response.
`timescale 1ns / 1ps

module pcst_stats_checker
    import pcst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  req_t                 req,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsp_t                 rsp,
    output int                   mismatches,
    output int                   owed
);

    localparam int NC = PCST_CPU_COUNT;
    localparam int NS = PCST_SCENE_COUNT;
    localparam int NM = PCST_METRIC_COUNT;

    logic [31:0]       sum_tbl   [NC][NS][NM];
    logic [31:0]       calls_tbl [NC][NS][NM];
    logic [TICK_W-1:0] peak_tbl  [NC][NS][NM];

    logic [SCENE_W-1:0] scene_reg;
    logic [SPR_W-1:0]   spr_all;
    logic [SPR_W-1:0]   spr_fast;
    logic [SPR_W-1:0]   spr_slow;

    rsp_t replies_due[$];

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: table response %s is %h, should be %h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic wipe_table();
        for (int c = 0; c < NC; c++)
            for (int s = 0; s < NS; s++)
                for (int m = 0; m < NM; m++)
                begin
                    sum_tbl[c][s][m] = '0;
                    calls_tbl[c][s][m] = '0;
                    peak_tbl[c][s][m] = '0;
                end
    endtask

    function automatic int landing_scene();
        if (scene_reg < NS)
            return scene_reg;
        if (PCST_OTHER_SCENE < NS)
            return PCST_OTHER_SCENE;
        return NS - 1;
    endfunction

    task automatic tally(input int c, input int m, input logic [31:0] ticks,
                         output logic ignored);
        int s;
        logic [TICK_W-1:0] t;
        t = ticks[TICK_W-1:0];
        ignored = 1'b1;
        if (c < NC && m < NM)
        begin
            s = landing_scene();
            sum_tbl[c][s][m] = sum_tbl[c][s][m] + {16'd0, t};
            calls_tbl[c][s][m] = calls_tbl[c][s][m] + 32'd1;
            if (t > peak_tbl[c][s][m])
                peak_tbl[c][s][m] = t;
            ignored = 1'b0;
        end
    endtask

    task automatic serve_request(input req_t r, output rsp_t reply);
        logic first_ign;
        logic second_ign;
        logic [ADDR_W-1:0] addr;
        reply = '0;
        addr = r.source_address[ADDR_W-1:0];
        case (r.op)
            OP_RECORD:
            begin
                tally(r.cpu, r.metric, r.elapsed, first_ign);
                reply.status = first_ign;
            end
            OP_SPRITE:
            begin
                tally(r.cpu, spr_all, r.elapsed, first_ign);
                if (addr >= WINDOW_LOW && addr < WINDOW_HIGH)
                    tally(r.cpu, spr_fast, r.elapsed, second_ign);
                else
                    tally(r.cpu, spr_slow, r.elapsed, second_ign);
                reply.status = first_ign | second_ign;
            end
            OP_READ:
            begin
                if (r.cpu >= NC || r.metric >= NM || r.read_scene >= NS)
                    reply.status = 1'b1;
                else
                begin
                    reply.tick_total = sum_tbl[r.cpu][r.read_scene][r.metric];
                    reply.call_total = calls_tbl[r.cpu][r.read_scene][r.metric];
                    reply.peak_ticks = peak_tbl[r.cpu][r.read_scene][r.metric];
                end
            end
            default:
                wipe_table();
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t reply;
        if (!rst_n)
        begin
            wipe_table();
            scene_reg = CURRENT_SCENE_RESET;
            spr_all = SPRITE_METRIC_RESET;
            spr_fast = SPRITE_FAST_RESET;
            spr_slow = SPRITE_SLOW_RESET;
            replies_due.delete();
            mismatches = 0;
            owed <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CURRENT_SCENE: scene_reg = cfg_data[SCENE_W-1:0];
                    REG_SPRITE_METRIC: spr_all = cfg_data[SPR_W-1:0];
                    REG_SPRITE_FAST:   spr_fast = cfg_data[SPR_W-1:0];
                    default:           spr_slow = cfg_data[SPR_W-1:0];
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (replies_due.size() == 0)
                    note_mismatch("with no item outstanding, tick_total", rsp.tick_total, '0);
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status)
                        note_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.tick_total !== want.tick_total)
                        note_mismatch("tick_total", rsp.tick_total, want.tick_total);
                    if (rsp.call_total !== want.call_total)
                        note_mismatch("call_total", rsp.call_total, want.call_total);
                    if (rsp.peak_ticks !== want.peak_ticks)
                        note_mismatch("peak_ticks", 32'(rsp.peak_ticks), 32'(want.peak_ticks));
                end
            end
            if (req_valid && req_ready)
            begin
                serve_request(req, reply);
                replies_due.push_back(reply);
            end
            owed <= replies_due.size();
        end
    end

endmodule

// ===== tb/perf_counter_stats_table_tb.sv =====
// Testbench top for the statistics table: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module perf_counter_stats_table_tb;
    import pcst_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp;

    int mismatches;
    int owed;
    bit quiet;
    int burst_left;

    always #10 clk = ~clk;

    perf_counter_stats_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    pcst_stats_checker u_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .owed       (owed)
    );

    initial
    begin
        #10_000_000;
        $display("perf_counter_stats_table regression: fail");
        $finish;
    end

    initial
    begin
        int stall_left;
        int seen;
        stall_left = 0;
        seen = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                seen++;
            if (seen == 300)
            begin
                seen++;
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (quiet)
                rsp_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                stall_left = $urandom_range(0, 5);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    function automatic req_t mk(input logic [1:0] op, input logic [CPU_W-1:0] cpu,
                                input logic [METRIC_W-1:0] metric, input logic [31:0] elapsed,
                                input logic [31:0] addr, input logic [SCENE_W-1:0] scene);
        req_t r;
        r.op = op;
        r.cpu = cpu;
        r.metric = metric;
        r.elapsed = elapsed;
        r.source_address = addr;
        r.read_scene = scene;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.op = OP_RECORD;
        else if (pick < 65)
            r.op = OP_SPRITE;
        else if (pick < 98)
            r.op = OP_READ;
        else
            r.op = OP_CLEAR;
        if ($urandom_range(0, 9) == 0)
            r.cpu = CPU_W'($urandom_range(PCST_CPU_COUNT, 3));
        else
            r.cpu = CPU_W'($urandom_range(0, PCST_CPU_COUNT - 1));
        if ($urandom_range(0, 9) == 0)
            r.metric = METRIC_W'($urandom_range(PCST_METRIC_COUNT, 15));
        else
            r.metric = METRIC_W'($urandom_range(0, PCST_METRIC_COUNT - 1));
        if ($urandom_range(0, 9) == 0)
            r.read_scene = SCENE_W'($urandom_range(PCST_SCENE_COUNT, 15));
        else
            r.read_scene = SCENE_W'($urandom_range(0, PCST_SCENE_COUNT - 1));
        case ($urandom_range(0, 3))
            0:       r.elapsed = $urandom;
            1:       r.elapsed = $urandom_range(0, 255);
            2:       r.elapsed = {16'($urandom), 16'hFF00 | 16'($urandom_range(0, 255))};
            default: r.elapsed = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 1) == 1)
            r.source_address = {3'($urandom), WINDOW_LOW + ADDR_W'($urandom_range(0, 'h3FFFF))};
        else
            r.source_address = $urandom;
        return r;
    endfunction

    task automatic offer(input req_t r);
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (!quiet)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [SCENE_W-1:0] scene, input logic [SPR_W-1:0] all_m,
                              input logic [SPR_W-1:0] fast_m, input logic [SPR_W-1:0] slow_m);
        cfg_write <= 1'b1;
        cfg_index <= REG_CURRENT_SCENE;
        cfg_data <= CFG_W'(scene);
        @(posedge clk);
        cfg_index <= REG_SPRITE_METRIC;
        cfg_data <= CFG_W'(all_m);
        @(posedge clk);
        cfg_index <= REG_SPRITE_FAST;
        cfg_data <= CFG_W'(fast_m);
        @(posedge clk);
        cfg_index <= REG_SPRITE_SLOW;
        cfg_data <= CFG_W'(slow_m);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_CURRENT_SCENE;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        quiet = 1'b0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_config(CURRENT_SCENE_RESET, SPRITE_METRIC_RESET, SPRITE_FAST_RESET,
                   SPRITE_SLOW_RESET);

        offer(mk(OP_READ, 0, 0, 0, 0, 0));
        offer(mk(OP_RECORD, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
        offer(mk(OP_RECORD, 0, 0, 32'h0001_0000, 0, 0));
        offer(mk(OP_RECORD, 1, 7, 32'h0000_1234, 0, 0));
        offer(mk(OP_RECORD, 2, 0, 32'h10, 0, 0));
        offer(mk(OP_RECORD, 3, 15, 32'h10, 0, 0));
        offer(mk(OP_RECORD, 0, 8, 32'h10, 0, 0));
        offer(mk(OP_SPRITE, 0, 0, 32'h5, 32'h0600_0000, 0));
        offer(mk(OP_SPRITE, 1, 0, 32'hABCD_0007, 32'hE603_FFFF, 0));
        offer(mk(OP_SPRITE, 0, 0, 32'h9, 32'h0604_0000, 0));
        offer(mk(OP_SPRITE, 0, 0, 32'h3, 32'h05FF_FFFF, 0));
        offer(mk(OP_SPRITE, 3, 0, 32'h3, 32'h0600_0000, 0));
        offer(mk(OP_READ, 0, 0, 0, 0, 0));
        offer(mk(OP_READ, 0, 1, 0, 0, 0));
        offer(mk(OP_READ, 0, 2, 0, 0, 0));
        offer(mk(OP_READ, 1, 7, 0, 0, 0));
        offer(mk(OP_READ, 1, 1, 0, 0, 0));
        offer(mk(OP_READ, 1, 0, 0, 0, 0));
        offer(mk(OP_READ, 0, 0, 0, 0, 8));
        offer(mk(OP_READ, 0, 0, 0, 0, 15));
        offer(mk(OP_READ, 2, 0, 0, 0, 0));
        offer(mk(OP_READ, 1, 9, 0, 0, 0));
        offer(mk(OP_CLEAR, 0, 0, 0, 0, 0));
        offer(mk(OP_READ, 0, 0, 0, 0, 0));
        offer(mk(OP_READ, 1, 7, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0:       set_config(4'd15, 3'd7, 3'd7, 3'd7);
                1:       set_config(4'd8, 3'd0, 3'd0, 3'd0);
                2:       set_config(4'd7, 3'd0, 3'd7, 3'd3);
                default: set_config(SCENE_W'($urandom_range(0, 15)), SPR_W'($urandom_range(0, 7)),
                                    SPR_W'($urandom_range(0, 7)), SPR_W'($urandom_range(0, 7)));
            endcase
            quiet = (ph % 4 == 3);
            for (int n = 0; n < 100; n++)
                offer(random_req());
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && owed == 0)
            $display("perf_counter_stats_table regression: pass");
        else
            $display("perf_counter_stats_table regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pcst_pkg.sv
hw/rtl/perf_counter_stats_table.sv
tb/pcst_stats_checker.sv
tb/perf_counter_stats_table_tb.sv
